// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Overlapping implication built on the macro above.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  `ASSERT_PROP(lbl, clk, rstn, (ante) |-> (cons), msg)

`endif

// ===== hdl/sgfc_pkg.sv =====
// Types, constants and helper functions of the smoothed gas index block.
package sgfc_pkg;

  localparam int unsigned WINDOW_DEF   = 12;
  localparam int unsigned MV_W         = 12;
  localparam int unsigned IDX_W        = 9;
  localparam int unsigned CAT_W        = 3;
  localparam int unsigned THR_W        = 9;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 12;
  localparam int unsigned IN_TDATA_W   = 16;
  localparam int unsigned OUT_TDATA_W  = 32;
  localparam int unsigned OUT_FIELDS_W = MV_W + IDX_W + CAT_W + 2;

  localparam int unsigned MV_PER_POINT = 3;
  localparam int unsigned HYST         = 5;

  localparam logic [IDX_W-1:0] FULL_SCALE_IDX = 9'd500;
  localparam logic [IDX_W-1:0] CAT_LIM_0      = 9'd50;
  localparam logic [IDX_W-1:0] CAT_LIM_1      = 9'd100;
  localparam logic [IDX_W-1:0] CAT_LIM_2      = 9'd150;
  localparam logic [IDX_W-1:0] CAT_LIM_3      = 9'd200;
  localparam logic [IDX_W-1:0] CAT_LIM_4      = 9'd300;

  localparam logic [MV_W-1:0]  BASE_MV_RST    = 12'd1000;
  localparam logic [THR_W-1:0] FAN_THR_RST    = 9'd175;
  localparam logic             AUTO_MODE_RST  = 1'b1;
  localparam logic             MANUAL_FAN_RST = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_MV    = 2'd0,
    CFG_FAN_THR    = 2'd1,
    CFG_AUTO_MODE  = 2'd2,
    CFG_MANUAL_FAN = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MULT,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_IDX_GO,
    ST_IDX_WAIT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic capture;
    logic update;
    logic mult;
    logic div_start;
    logic div_sel_idx;
    logic save_avg;
    logic save_idx;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } dp_stat_t;

  function automatic logic [CAT_W-1:0] category_of(input logic [IDX_W-1:0] idx);
    logic [CAT_W-1:0] cat;
    if (idx <= CAT_LIM_0) cat = 3'd0;
    else if (idx <= CAT_LIM_1) cat = 3'd1;
    else if (idx <= CAT_LIM_2) cat = 3'd2;
    else if (idx <= CAT_LIM_3) cat = 3'd3;
    else if (idx <= CAT_LIM_4) cat = 3'd4;
    else cat = 3'd5;
    return cat;
  endfunction

endpackage

// ===== hdl/sgfc_ctrl.sv =====
// Sequencing state machine of the smoothed gas index block.
module sgfc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sgfc_pkg::dp_stat_t stat_i,
  output sgfc_pkg::dp_cmd_t  cmd_o
);
  import sgfc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_MULT;
      end
      ST_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = ST_AVG_GO;
      end
      ST_AVG_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        if (!stat_i.div_busy) begin
          cmd_o.save_avg = 1'b1;
          state_d        = ST_IDX_GO;
        end
      end
      ST_IDX_GO: begin
        cmd_o.div_start   = 1'b1;
        cmd_o.div_sel_idx = 1'b1;
        state_d           = ST_IDX_WAIT;
      end
      ST_IDX_WAIT: begin
        if (!stat_i.div_busy) begin
          cmd_o.save_idx = 1'b1;
          state_d        = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/sgfc_dp.sv =====
// Datapath: sample ring, running sum, shared divider, fan logic and output register.
module sgfc_dp #(
  parameter int unsigned WINDOW = sgfc_pkg::WINDOW_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sgfc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sgfc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [sgfc_pkg::MV_W-1:0]        sample_i,
  input  sgfc_pkg::dp_cmd_t                cmd_i,
  output sgfc_pkg::dp_stat_t               stat_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sgfc_pkg::OUT_TDATA_W-1:0] out_data_o
);
  import sgfc_pkg::*;

  localparam int unsigned PTR_W  = $clog2(WINDOW);
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = MV_W + $clog2(WINDOW);
  localparam int unsigned BT_W   = MV_W + CNT_W;
  localparam int unsigned DIV_W  = ((SUM_W + 1) / 2) * 2;
  localparam int unsigned ITERS  = DIV_W / 2;
  localparam int unsigned ITER_W = $clog2(ITERS + 1);
  localparam int unsigned DVS_W  = $clog2(MV_PER_POINT * WINDOW + 1);

  // Configuration registers
  logic [MV_W-1:0]  base_mv_q;
  logic [THR_W-1:0] fan_thr_q;
  logic             auto_mode_q;
  logic             manual_fan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_mv_q    <= BASE_MV_RST;
      fan_thr_q    <= FAN_THR_RST;
      auto_mode_q  <= AUTO_MODE_RST;
      manual_fan_q <= MANUAL_FAN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_BASE_MV:    base_mv_q    <= cfg_wdata_i[MV_W-1:0];
        CFG_FAN_THR:    fan_thr_q    <= cfg_wdata_i[THR_W-1:0];
        CFG_AUTO_MODE:  auto_mode_q  <= cfg_wdata_i[0];
        CFG_MANUAL_FAN: manual_fan_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Sample ring and window bookkeeping
  logic [MV_W-1:0]  ring_mem [WINDOW];
  logic [MV_W-1:0]  sample_q;
  logic [MV_W-1:0]  old_q;
  logic [PTR_W-1:0] pos_q, pos_d;
  logic             full_q, full_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [SUM_W-1:0] drop;
  logic             wrap;

  // The oldest entry is read while the new item is captured; it is only
  // used once the ring has wrapped, so it was always written before.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sample_q <= sample_i;
      old_q    <= ring_mem[pos_q];
    end
    if (cmd_i.update) begin
      ring_mem[pos_q] <= sample_q;
    end
  end

  always_comb begin
    wrap    = (pos_q == PTR_W'(WINDOW - 1));
    pos_d   = wrap ? '0 : pos_q + PTR_W'(1);
    full_d  = full_q | wrap;
    count_d = full_d ? CNT_W'(WINDOW) : CNT_W'(pos_d);
    drop    = full_q ? SUM_W'(old_q) : '0;
    sum_d   = sum_q - drop + SUM_W'(sample_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      full_q  <= 1'b0;
      count_q <= '0;
      sum_q   <= '0;
    end else if (cmd_i.update) begin
      pos_q   <= pos_d;
      full_q  <= full_d;
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

  // Baseline total for the current fill count
  logic [BT_W-1:0] base_total_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mult) begin
      base_total_q <= BT_W'(base_mv_q) * BT_W'(count_q);
    end
  end

  // Shared restoring divider, two quotient bits per cycle
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DVS_W:0]    rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q;
  logic [ITER_W-1:0] iter_q;
  logic              busy_q;
  logic [DIV_W-1:0]  dividend;
  logic [DVS_W-1:0]  divisor;
  logic [SUM_W-1:0]  diff;
  logic              diff_pos;

  always_comb begin
    diff_pos = (BT_W'(sum_q) > base_total_q);
    diff     = sum_q - SUM_W'(base_total_q);
    if (cmd_i.div_sel_idx) begin
      dividend = diff_pos ? DIV_W'(diff) : '0;
      divisor  = DVS_W'(count_q) + (DVS_W'(count_q) << 1);
    end else begin
      dividend = DIV_W'(sum_q);
      divisor  = DVS_W'(count_q);
    end
  end

  always_comb begin
    logic [DVS_W:0] shifted;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int k = 0; k < 2; k++) begin
      shifted = {rem_d[DVS_W-1:0], quo_d[DIV_W-1]};
      quo_d   = quo_d << 1;
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d    = shifted - {1'b0, dvs_q};
        quo_d[0] = 1'b1;
      end else begin
        rem_d = shifted;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= '0;
    end else if (cmd_i.div_start) begin
      busy_q <= 1'b1;
      iter_q <= ITER_W'(ITERS);
    end else if (busy_q) begin
      iter_q <= iter_q - ITER_W'(1);
      if (iter_q == ITER_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q <= dividend;
      rem_q <= '0;
      dvs_q <= divisor;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  // Results of the two divisions
  logic [MV_W-1:0]  avg_q;
  logic [IDX_W-1:0] idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.save_avg) begin
      avg_q <= quo_q[MV_W-1:0];
    end
    if (cmd_i.save_idx) begin
      idx_q <= (quo_q > DIV_W'(FULL_SCALE_IDX)) ? FULL_SCALE_IDX : quo_q[IDX_W-1:0];
    end
  end

  // Fan control in auto mode: on at or above the threshold, off at or below threshold
  // minus the hysteresis, which can never be reached for small thresholds.
  logic fan_q, fan_d;
  logic hit_on, hit_off;

  always_comb begin
    hit_on  = (idx_q >= fan_thr_q);
    hit_off = (({1'b0, idx_q} + (THR_W + 1)'(HYST)) <= {1'b0, fan_thr_q});
    if (!auto_mode_q) begin
      fan_d = manual_fan_q;
    end else if (!fan_q && hit_on) begin
      fan_d = 1'b1;
    end else if (fan_q && hit_off) begin
      fan_d = 1'b0;
    end else begin
      fan_d = fan_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fan_q <= 1'b0;
    end else if (cmd_i.emit) begin
      fan_q <= fan_d;
    end
  end

  // Output register
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= OUT_TDATA_W'({fan_d ^ fan_q, fan_d, category_of(idx_q), idx_q, avg_q});
    end
  end

  assign stat_o.div_busy = busy_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;

endmodule

// ===== hdl/smoothed_gas_index_fan_control.sv =====
// Top level of the smoothed gas index and fan control block.
// Each item is one sensor reading in millivolts; the block keeps the last WINDOW readings in a
// ring, and for every item returns one result with the moving average, the air index
// (0 to 500, 3 mV per point above the clean-air baseline), its category and the fan state
// with a flag when the fan toggled. Items are handled one at a time: the item is accepted,
// the ring and running sum are updated, the baseline total is formed, then two divisions run
// on a shared divider that retires two quotient bits per cycle; each division is started,
// runs over a dividend of SUM_W = 12 + clog2(WINDOW) bits rounded up to an even width, and
// saves its quotient. The output register is then loaded once it is free. A finished result
// waits in the output register while the next item is accepted. Configuration registers
// must be written through the write port only while the block is idle, which the block
// itself does not enforce; they take effect from the next item.
module smoothed_gas_index_fan_control #(
  parameter int unsigned WINDOW = sgfc_pkg::WINDOW_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sgfc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sgfc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // sample_mv [11:0], zero padding above
  input  logic [sgfc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // smoothed_mv [11:0], air_index [20:12], category [23:21], fan_on [24],
  // fan_changed [25], zero padding above
  output logic [sgfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import sgfc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sgfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sgfc_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (s_axis_tdata[MV_W-1:0]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== hdl/sgfc_checker.sv =====
// Port-level checks of the smoothed gas index block and their binding to the top level.
`include "assert_macros.svh"

module sgfc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [sgfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import sgfc_pkg::*;

  logic [IDX_W-1:0] air_index;
  logic [CAT_W-1:0] category;

  assign air_index = m_axis_tdata[MV_W+IDX_W-1:MV_W];
  assign category  = m_axis_tdata[MV_W+IDX_W+CAT_W-1:MV_W+IDX_W];

  // A stalled result keeps its value.
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, ##1 (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

  // Only one item is in work at a time, so the block is busy right after accepting.
  `ASSERT_IMPL(a_one_in_work, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, ##1 !s_axis_tready, "item accepted while another is in work")

  `ASSERT_IMPL(a_index_cap, clk_i, rst_ni, m_axis_tvalid, air_index <= FULL_SCALE_IDX, "air index above full scale")

  `ASSERT_IMPL(a_cat_low, clk_i, rst_ni, m_axis_tvalid && (air_index <= CAT_LIM_0), category == 3'd0, "category does not match a low index")

  `ASSERT_IMPL(a_cat_high, clk_i, rst_ni, m_axis_tvalid && (air_index > CAT_LIM_4), category == 3'd5, "category does not match a high index")

endmodule

bind smoothed_gas_index_fan_control sgfc_checker u_sgfc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/smoothed_gas_index_fan_control_test.sv =====
// Self-checking testbench for the smoothed gas index and fan control block.
module smoothed_gas_index_fan_control_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sgfc_pkg::*;

  localparam int unsigned WINDOW          = WINDOW_DEF;
  localparam int unsigned PHASES          = 10;
  localparam int unsigned ITEMS_PER_PHASE = 78;
  localparam int unsigned CYCLE_LIMIT     = 600000;
  localparam int unsigned HOLD_A          = 3000;
  localparam int unsigned HOLD_B          = 20000;
  localparam int unsigned HOLD_LEN        = 600;
  localparam int unsigned MAX_REPORTS     = 200;

  typedef enum logic [2:0] {
    CAT_GOOD, CAT_MODERATE, CAT_SENSITIVE, CAT_UNHEALTHY, CAT_VERY_UNHEALTHY, CAT_HAZARDOUS
  } air_cat_e;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_MOSTLY, RDY_SELDOM, RDY_PERIODIC} ready_pattern_e;

  typedef struct packed {
    logic [MV_W-1:0]  smoothed;
    logic [IDX_W-1:0] index;
    air_cat_e         category;
    logic             fan_on;
    logic             fan_changed;
  } gas_grade_t;

  typedef struct {
    row_kind_e   kind;
    cfg_reg_e    reg_sel;
    logic [11:0] value;
    bit          known;
    gas_grade_t  want;
  } stim_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  cfg_reg_e               cfg_idx_i = CFG_BASE_MV;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  smoothed_gas_index_fan_control dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow state of the block, advanced once per accepted item.
  logic [MV_W-1:0]  mv_ring [WINDOW];
  int unsigned      ring_pos = 0;
  bit               ring_filled = 1'b0;
  logic [15:0]      mv_sum = '0;
  logic             fan_now = 1'b0;
  logic [MV_W-1:0]  cfg_base = BASE_MV_RST;
  logic [THR_W-1:0] cfg_thr = FAN_THR_RST;
  logic             cfg_auto = AUTO_MODE_RST;
  logic             cfg_manual = MANUAL_FAN_RST;

  gas_grade_t  pending_grades [$];
  stim_row_t   directed_rows [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int          idx_marks [15] = '{0, 50, 51, 100, 101, 150, 151, 200, 201, 300, 301, 499, 500,
                                   501, 520};

  function automatic air_cat_e category_for(input int unsigned level);
    if (level <= CAT_LIM_0) return CAT_GOOD;
    if (level <= CAT_LIM_1) return CAT_MODERATE;
    if (level <= CAT_LIM_2) return CAT_SENSITIVE;
    if (level <= CAT_LIM_3) return CAT_UNHEALTHY;
    if (level <= CAT_LIM_4) return CAT_VERY_UNHEALTHY;
    return CAT_HAZARDOUS;
  endfunction

  function automatic gas_grade_t grade_sample(input logic [MV_W-1:0] s);
    gas_grade_t  r;
    int unsigned fill;
    int unsigned base_total;
    int unsigned level;
    int          hi;
    int          lo;
    logic        was_on;
    if (ring_filled) mv_sum = mv_sum - mv_ring[ring_pos];
    mv_ring[ring_pos] = s;
    mv_sum = mv_sum + s;
    ring_pos = (ring_pos + 1) % WINDOW;
    if (ring_pos == 0) ring_filled = 1'b1;
    fill = ring_filled ? WINDOW : ring_pos;
    base_total = cfg_base * fill;
    if (mv_sum <= base_total) begin
      level = 0;
    end else begin
      level = (mv_sum - base_total) / (MV_PER_POINT * fill);
      if (level > FULL_SCALE_IDX) level = FULL_SCALE_IDX;
    end
    was_on = fan_now;
    if (cfg_auto) begin
      // The off level is signed; below a threshold of five it cannot be reached.
      hi = int'(cfg_thr);
      lo = hi - int'(HYST);
      if (!was_on && int'(level) >= hi) fan_now = 1'b1;
      else if (was_on && int'(level) <= lo) fan_now = 1'b0;
    end else begin
      fan_now = cfg_manual;
    end
    r.smoothed    = MV_W'(mv_sum / fill);
    r.index       = IDX_W'(level);
    r.category    = category_for(level);
    r.fan_on      = fan_now;
    r.fan_changed = fan_now != was_on;
    return r;
  endfunction

  function automatic stim_row_t item_row(input logic [11:0] s);
    stim_row_t row;
    row.kind    = ROW_ITEM;
    row.reg_sel = CFG_BASE_MV;
    row.value   = s;
    row.known   = 1'b0;
    row.want    = '0;
    return row;
  endfunction

  function automatic stim_row_t typed_row(input logic [11:0] s, input logic [MV_W-1:0] avg,
                                          input logic [IDX_W-1:0] level, input air_cat_e cat,
                                          input logic fan, input logic toggled);
    stim_row_t row;
    row = item_row(s);
    row.known = 1'b1;
    row.want  = '{smoothed: avg, index: level, category: cat, fan_on: fan,
                  fan_changed: toggled};
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input cfg_reg_e sel, input logic [11:0] v);
    stim_row_t row;
    row = item_row(v);
    row.kind    = ROW_CFG;
    row.reg_sel = sel;
    return row;
  endfunction

  task automatic build_table();
    directed_rows.push_back(typed_row(12'd0, 12'd0, 9'd0, CAT_GOOD, 1'b0, 1'b0));
    directed_rows.push_back(typed_row(12'd4095, 12'd2047, 9'd349, CAT_HAZARDOUS, 1'b1, 1'b1));
    directed_rows.push_back(typed_row(12'd4095, 12'd2730, 9'd500, CAT_HAZARDOUS, 1'b1, 1'b0));
    repeat (9) directed_rows.push_back(item_row(12'd4095));
    // Ring wraps here: the oldest zero leaves and the sum reaches its maximum.
    directed_rows.push_back(typed_row(12'd4095, 12'd4095, 9'd500, CAT_HAZARDOUS, 1'b1, 1'b0));
    directed_rows.push_back(cfg_row(CFG_AUTO_MODE, 12'd0));
    directed_rows.push_back(item_row(12'd0));
    directed_rows.push_back(cfg_row(CFG_MANUAL_FAN, 12'd1));
    directed_rows.push_back(item_row(12'd0));
    directed_rows.push_back(cfg_row(CFG_AUTO_MODE, 12'd1));
    directed_rows.push_back(cfg_row(CFG_FAN_THR, 12'd0));
    directed_rows.push_back(cfg_row(CFG_BASE_MV, 12'd4095));
    directed_rows.push_back(item_row(12'd0));
    directed_rows.push_back(cfg_row(CFG_FAN_THR, 12'd511));
    directed_rows.push_back(item_row(12'd0));
    directed_rows.push_back(item_row(12'd4095));
    directed_rows.push_back(cfg_row(CFG_BASE_MV, 12'd0));
    directed_rows.push_back(cfg_row(CFG_FAN_THR, 12'd500));
    directed_rows.push_back(item_row(12'd4095));
    directed_rows.push_back(cfg_row(CFG_AUTO_MODE, 12'd0));
    directed_rows.push_back(cfg_row(CFG_MANUAL_FAN, 12'd0));
    directed_rows.push_back(item_row(12'd4095));
    directed_rows.push_back(cfg_row(CFG_AUTO_MODE, 12'd1));
    directed_rows.push_back(cfg_row(CFG_BASE_MV, 12'd1000));
    directed_rows.push_back(cfg_row(CFG_FAN_THR, 12'd175));
    directed_rows.push_back(item_row(12'd0));
    directed_rows.push_back(item_row(12'h800));
    directed_rows.push_back(item_row(12'h555));
    directed_rows.push_back(item_row(12'hAAA));
  endtask

  // Caller lowers the write enable once the last register of a group is written.
  task automatic put_reg(input cfg_reg_e sel, input logic [11:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= sel;
    cfg_wdata_i <= v;
    case (sel)
      CFG_BASE_MV:    cfg_base   = v[MV_W-1:0];
      CFG_FAN_THR:    cfg_thr    = v[THR_W-1:0];
      CFG_AUTO_MODE:  cfg_auto   = v[0];
      CFG_MANUAL_FAN: cfg_manual = v[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_item(input logic [MV_W-1:0] s, input bit known, input gas_grade_t want);
    gas_grade_t got;
    s_axis_tdata  <= IN_TDATA_W'(s);
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    got = grade_sample(s);
    pending_grades.push_back(known ? want : got);
  endtask

  task automatic offer(input logic [MV_W-1:0] s);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    send_item(s, 1'b0, '0);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_grades.size() != 0);
  endtask

  task automatic set_registers(input int ph);
    logic [11:0] base;
    logic [11:0] thr;
    logic [11:0] auto_on;
    logic [11:0] man;
    base    = 12'($urandom_range(0, 2000));
    thr     = 12'($urandom_range(5, 500));
    auto_on = 12'($urandom_range(0, 3) != 0);
    man     = 12'($urandom_range(0, 1));
    case (ph)
      0: begin base = 1000; thr = 175; auto_on = 1; man = 0; end
      1: begin base = 0; thr = 5; auto_on = 1; end
      2: begin base = 4095; thr = 500; auto_on = 1; man = 1; end
      3: begin
        base = 12'($urandom_range(300, 1500)); thr = 12'($urandom_range(0, 4)); auto_on = 1;
      end
      4: begin base = 12'($urandom_range(300, 1500)); thr = 511; auto_on = 1; end
      5: begin base = 12'($urandom_range(500, 1200)); auto_on = 0; man = 1; end
      6: begin base = 12'($urandom_range(500, 1200)); auto_on = 0; man = 0; end
      7: begin base = 1000; thr = 500; auto_on = 1; end
      default: ;
    endcase
    put_reg(CFG_BASE_MV, base);
    put_reg(CFG_FAN_THR, thr);
    put_reg(CFG_AUTO_MODE, auto_on);
    put_reg(CFG_MANUAL_FAN, man);
    cfg_we_i <= 1'b0;
  endtask

  // Index to dwell on: category edges and full scale, the fan switching levels, or anywhere.
  function automatic int pick_target();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return idx_marks[$urandom_range(0, 14)];
    if (sel < 8) return int'(cfg_thr) + int'($urandom_range(0, 7)) - 6;
    return $urandom_range(0, 520);
  endfunction

  function automatic logic [MV_W-1:0] sample_for(input int t);
    int v;
    if (t < 0) v = int'(cfg_base) - int'($urandom_range(1, 60));
    else v = int'(cfg_base) + 3 * t + int'($urandom_range(0, 2));
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[MV_W-1:0];
  endfunction

  initial begin
    bit pending;
    bit paused;
    int left;
    int len;
    int t;
    pending = 1'b0;
    paused  = 1'b0;
    build_table();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        if (pending) begin
          drain();
          pending = 1'b0;
        end
        put_reg(directed_rows[i].reg_sel, directed_rows[i].value);
        if (i + 1 == directed_rows.size() || directed_rows[i + 1].kind != ROW_CFG)
          cfg_we_i <= 1'b0;
      end else begin
        send_item(directed_rows[i].value[MV_W-1:0], directed_rows[i].known,
                  directed_rows[i].want);
        pending = 1'b1;
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      set_registers(ph);
      left = ITEMS_PER_PHASE;
      while (left > 0) begin
        if (ph == 4 && !paused && left <= ITEMS_PER_PHASE / 2) begin
          drain();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 7) begin
          // Steady stretch so the average settles on the chosen index.
          len = $urandom_range(6, 18);
          if (len > left) len = left;
          t = pick_target();
          repeat (len) offer(sample_for(t));
        end else begin
          len = $urandom_range(1, 6);
          if (len > left) len = left;
          repeat (len) begin
            case ($urandom_range(0, 9))
              0: offer(12'd0);
              1: offer(12'd4095);
              default: offer(MV_W'($urandom_range(0, 4095)));
            endcase
          end
        end
        left -= len;
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("smoothed_gas_index_fan_control_test: PASS");
    end else begin
      $display("smoothed_gas_index_fan_control_test: FAIL");
    end
    $finish;
  end

  // Receiver: changing ready patterns, plus two long hold-offs that back the block up.
  int unsigned    hold_left = 0;
  int unsigned    pattern_left = 0;
  ready_pattern_e pattern = RDY_ALWAYS;

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (cycle_count == HOLD_A || cycle_count == HOLD_B) begin
      hold_left     <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern      <= ready_pattern_e'($urandom_range(0, 3));
        pattern_left <= $urandom_range(16, 160);
      end else begin
        pattern_left <= pattern_left - 1;
      end
      case (pattern)
        RDY_ALWAYS: m_axis_tready <= 1'b1;
        RDY_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
        RDY_SELDOM: m_axis_tready <= ($urandom_range(0, 4) == 0);
        default:    m_axis_tready <= cycle_count[2];
      endcase
    end
  end

  task automatic compare_field(input string what, input logic [11:0] want,
                               input logic [11:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    gas_grade_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_grades.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result expected none actual %h", $time, m_axis_tdata);
      end else begin
        want = pending_grades.pop_front();
        compare_field("smoothed_mv", want.smoothed, m_axis_tdata[11:0]);
        compare_field("air_index", 12'(want.index), 12'(m_axis_tdata[20:12]));
        compare_field("category", 12'(want.category), 12'(m_axis_tdata[23:21]));
        compare_field("fan_on", 12'(want.fan_on), 12'(m_axis_tdata[24]));
        compare_field("fan_changed", 12'(want.fan_changed), 12'(m_axis_tdata[25]));
        compare_field("padding", 12'd0, 12'(m_axis_tdata[31:26]));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("smoothed_gas_index_fan_control_test: FAIL");
      $finish;
    end
  end

endmodule

// ===== smoothed_gas_index_fan_control.f =====
+incdir+hdl
hdl/sgfc_pkg.sv
hdl/sgfc_ctrl.sv
hdl/sgfc_dp.sv
hdl/smoothed_gas_index_fan_control.sv
hdl/sgfc_checker.sv
tb/smoothed_gas_index_fan_control_test.sv
